// ===== rtl/core/igov_pkg.sv =====
// Shared types, codes and widths of the idle state governor.
package igov_pkg;

	localparam int SLEEP_W   = 32;
	localparam int COUNT_W   = 32;
	localparam int TIME_W    = 48;
	localparam int STAT_W    = COUNT_W + TIME_W;
	localparam int LAT_W     = 20;
	localparam int LAT3_W    = LAT_W + 2;
	localparam int N_LAT     = 6;
	localparam int NSTATE_W  = 4;
	localparam int STATE_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 20;
	localparam int FIRST_TESTED = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_S2     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_S7     = 3'd6;

	localparam logic [NSTATE_W-1:0] NUM_STATES_RST = 4'd2;
	localparam logic [STATE_W-1:0]  STATE_FALLBACK = 3'd1;

	typedef enum logic [1:0] {
		REQ_SELECT   = 2'd0,
		REQ_COMPLETE = 2'd1,
		REQ_QUERY    = 2'd2
	} req_t;

	// latencies are held pre-multiplied by three
	typedef struct packed {
		logic [NSTATE_W-1:0]          num_states;
		logic [N_LAT-1:0][LAT3_W-1:0] lat3;
	} cfg_t;

endpackage

// ===== rtl/core/igov_ram.sv =====
// Generic single-port-write, registered-read RAM.
module igov_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== rtl/core/igov_select.sv =====
// Idle state choice: deepest enabled state whose tripled latency is below the last sleep.
module igov_select #(
	parameter int MAX_STATES = 8
) (
	input  igov_pkg::cfg_t                      cfg,
	input  logic [igov_pkg::SLEEP_W-1:0]        sleep,
	output logic [igov_pkg::STATE_W-1:0]        chosen
);

	logic [igov_pkg::NSTATE_W-1:0] n_eff;

	always_comb begin
		n_eff = (cfg.num_states > igov_pkg::NSTATE_W'(MAX_STATES)) ?
			igov_pkg::NSTATE_W'(MAX_STATES) : cfg.num_states;
	end

	// ascending scan, so the deepest qualifying state wins
	always_comb begin
		chosen = igov_pkg::STATE_FALLBACK;
		for (int s = igov_pkg::FIRST_TESTED; s < igov_pkg::FIRST_TESTED + igov_pkg::N_LAT;
				s++) begin
			if (s < MAX_STATES && igov_pkg::NSTATE_W'(s) < n_eff &&
					sleep > igov_pkg::SLEEP_W'(cfg.lat3[s - igov_pkg::FIRST_TESTED])) begin
				chosen = igov_pkg::STATE_W'(s);
			end
		end
	end

endmodule

// ===== rtl/core/idle_state_governor.sv =====
// Idle state governor top level: request pipeline, statistics memories and forwarding.
//
// Input channel (in_valid/in_ready) carries one request beat: select, completion or
// query, for one CPU and idle state. Output channel (out_valid/out_ready) returns
// exactly one result beat per request: chosen_state for a select, usage_count and
// usage_time for a query, all zeros otherwise.
// The synchronous memory read is issued when the request beat is accepted; the
// update and the result register follow when the read stage advances into the
// output register.
// Throughput: one request per cycle when not stalled. The last-sleep and statistics
// memories are read at acceptance, written back as the read stage advances; a
// forwarding register per memory covers a same-entry request in the very next cycle.
// Reset clears the configuration to two states with zero latencies and clears the
// per-entry valid bits, so every entry reads as zero; no clearing pass is needed and
// requests are taken from the first cycle after reset.
// When the receiver stalls, the result waits in the output register; one further
// request is still taken and waits in the read stage, after which in_ready drops.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// expected only while no request is in flight.
module idle_state_governor #(
	parameter int NUM_CPUS   = 8,
	parameter int MAX_STATES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [igov_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [igov_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic [2:0]                        cpu,
	input  logic [2:0]                        state_index,
	input  logic                              entered_ok,
	input  logic [31:0]                       elapsed_us,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [igov_pkg::STATE_W-1:0]      chosen_state,
	output logic [igov_pkg::COUNT_W-1:0]      usage_count,
	output logic [igov_pkg::TIME_W-1:0]       usage_time
);

	localparam int CPU_AW   = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
	localparam int ST_DEPTH = NUM_CPUS * MAX_STATES;
	localparam int ST_AW    = $clog2(ST_DEPTH);

	igov_pkg::cfg_t cfg_q;

	logic in_acc;
	logic adv_s1;

	logic                              valid_s1;
	igov_pkg::req_t                    req_s1;
	logic                              cpu_ok_s1;
	logic                              st_ok_s1;
	logic                              ok_s1;
	logic [igov_pkg::SLEEP_W-1:0]      elapsed_s1;
	logic [CPU_AW-1:0]                 ls_addr_s1;
	logic [ST_AW-1:0]                  st_addr_s1;
	logic                              ls_vld_s1;
	logic                              st_vld_s1;

	logic [NUM_CPUS-1:0]               ls_vld_q;
	logic [ST_DEPTH-1:0]               st_vld_q;

	logic                              ls_fwd_vld_q;
	logic [CPU_AW-1:0]                 ls_fwd_addr_q;
	logic [igov_pkg::SLEEP_W-1:0]      ls_fwd_data_q;
	logic                              st_fwd_vld_q;
	logic [ST_AW-1:0]                  st_fwd_addr_q;
	logic [igov_pkg::STAT_W-1:0]       st_fwd_data_q;

	logic [CPU_AW-1:0]                 ls_raddr;
	logic [ST_AW-1:0]                  st_raddr;
	logic [igov_pkg::SLEEP_W-1:0]      ls_rdata;
	logic [igov_pkg::STAT_W-1:0]       st_rdata;

	logic [igov_pkg::SLEEP_W-1:0]      ls_cur;
	logic [igov_pkg::STAT_W-1:0]       st_cur;
	logic [igov_pkg::COUNT_W-1:0]      cur_count;
	logic [igov_pkg::TIME_W-1:0]       cur_time;
	logic [igov_pkg::SLEEP_W-1:0]      sel_sleep;
	logic [igov_pkg::STATE_W-1:0]      sel_state;

	logic                              ls_we;
	logic [igov_pkg::SLEEP_W-1:0]      ls_wdata;
	logic                              st_we;
	logic [igov_pkg::STAT_W-1:0]       st_wdata;

	logic [igov_pkg::STATE_W-1:0]      res_chosen;
	logic [igov_pkg::COUNT_W-1:0]      res_count;
	logic [igov_pkg::TIME_W-1:0]       res_time;

	logic                              out_valid_q;
	logic [igov_pkg::STATE_W-1:0]      chosen_q;
	logic [igov_pkg::COUNT_W-1:0]      count_q;
	logic [igov_pkg::TIME_W-1:0]       time_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_states <= igov_pkg::NUM_STATES_RST;
			cfg_q.lat3       <= '0;
		end else if (cfg_we) begin
			if (cfg_index == igov_pkg::REG_NUM_STATES) begin
				cfg_q.num_states <= cfg_data[igov_pkg::NSTATE_W-1:0];
			end else if (cfg_index >= igov_pkg::REG_LAT_S2 &&
					cfg_index <= igov_pkg::REG_LAT_S7) begin
				cfg_q.lat3[cfg_index - igov_pkg::REG_LAT_S2] <=
					{2'b00, cfg_data[igov_pkg::LAT_W-1:0]} +
					{1'b0, cfg_data[igov_pkg::LAT_W-1:0], 1'b0};
			end
		end
	end

	// handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	assign ls_raddr = CPU_AW'(cpu);
	assign st_raddr = ST_AW'(32'(cpu) * MAX_STATES + 32'(state_index));

	igov_ram #(
		.WIDTH(igov_pkg::SLEEP_W),
		.DEPTH(NUM_CPUS)
	) u_ls_ram (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_addr_s1),
		.wdata (ls_wdata),
		.re    (in_acc),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	igov_ram #(
		.WIDTH(igov_pkg::STAT_W),
		.DEPTH(ST_DEPTH)
	) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_addr_s1),
		.wdata (st_wdata),
		.re    (in_acc),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1     <= igov_pkg::req_t'(req_type);
			cpu_ok_s1  <= 32'(cpu) < NUM_CPUS;
			st_ok_s1   <= 32'(state_index) < MAX_STATES;
			ok_s1      <= entered_ok;
			elapsed_s1 <= elapsed_us;
			ls_addr_s1 <= ls_raddr;
			st_addr_s1 <= st_raddr;
			ls_vld_s1  <= ls_vld_q[ls_raddr];
			st_vld_s1  <= st_vld_q[st_raddr];
		end
	end

	// the forwarding registers always hold the latest write to each memory
	always_comb begin
		if (ls_fwd_vld_q && ls_fwd_addr_q == ls_addr_s1) begin
			ls_cur = ls_fwd_data_q;
		end else begin
			ls_cur = ls_vld_s1 ? ls_rdata : '0;
		end
		if (st_fwd_vld_q && st_fwd_addr_q == st_addr_s1) begin
			st_cur = st_fwd_data_q;
		end else begin
			st_cur = st_vld_s1 ? st_rdata : '0;
		end
	end

	assign cur_count = st_cur[igov_pkg::STAT_W-1:igov_pkg::TIME_W];
	assign cur_time  = st_cur[igov_pkg::TIME_W-1:0];
	assign sel_sleep = cpu_ok_s1 ? ls_cur : '0;

	igov_select #(
		.MAX_STATES(MAX_STATES)
	) u_select (
		.cfg    (cfg_q),
		.sleep  (sel_sleep),
		.chosen (sel_state)
	);

	// update and result
	always_comb begin
		res_chosen = '0;
		res_count  = '0;
		res_time   = '0;
		ls_we      = 1'b0;
		st_we      = 1'b0;
		ls_wdata   = ok_s1 ? elapsed_s1 : '0;
		st_wdata   = {cur_count + igov_pkg::COUNT_W'(1),
			cur_time + igov_pkg::TIME_W'(elapsed_s1)};
		unique case (req_s1)
			igov_pkg::REQ_SELECT: begin
				res_chosen = sel_state;
			end
			igov_pkg::REQ_COMPLETE: begin
				if (cpu_ok_s1 && st_ok_s1) begin
					ls_we = adv_s1;
					st_we = adv_s1 && ok_s1;
				end
			end
			igov_pkg::REQ_QUERY: begin
				if (cpu_ok_s1 && st_ok_s1) begin
					res_count = cur_count;
					res_time  = cur_time;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_vld_q     <= '0;
			st_vld_q     <= '0;
			ls_fwd_vld_q <= 1'b0;
			st_fwd_vld_q <= 1'b0;
		end else begin
			if (ls_we) begin
				ls_vld_q[ls_addr_s1] <= 1'b1;
				ls_fwd_vld_q         <= 1'b1;
			end
			if (st_we) begin
				st_vld_q[st_addr_s1] <= 1'b1;
				st_fwd_vld_q         <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ls_we) begin
			ls_fwd_addr_q <= ls_addr_s1;
			ls_fwd_data_q <= ls_wdata;
		end
		if (st_we) begin
			st_fwd_addr_q <= st_addr_s1;
			st_fwd_data_q <= st_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chosen_q <= res_chosen;
			count_q  <= res_count;
			time_q   <= res_time;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_state = chosen_q;
	assign usage_count  = count_q;
	assign usage_time   = time_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted beat did not reach the read stage");

	a_ls_fwd_marked: assert property (@(posedge clk) disable iff (!arst_n)
		ls_fwd_vld_q |-> ls_vld_q[ls_fwd_addr_q])
		else $error("forwarded last-sleep entry not marked valid");

	a_st_fwd_marked: assert property (@(posedge clk) disable iff (!arst_n)
		st_fwd_vld_q |-> st_vld_q[st_fwd_addr_q])
		else $error("forwarded statistics entry not marked valid");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && chosen_q != '0) |-> (count_q == '0 && time_q == '0))
		else $error("select result carries statistics");

endmodule
